@@ rtl/pcvu_pkg.sv @@
package pcvu_pkg;

    // Default sizes of the stores and the fixed-point format.
    localparam int C_MAX_PARTICLES = 256;
    localparam int C_MAX_IMAGES    = 27;
    localparam int C_FRAC_BITS     = 16;

    // Image counts for the two modes.
    localparam int C_IMG_3D = 27;
    localparam int C_IMG_2D = 9;

    // Field widths.
    localparam int C_WORD_W = 32;
    localparam int C_IDX_W  = 8;
    localparam int C_OP_W   = 3;
    localparam int C_CFG_W  = 17;
    localparam int C_ROW_W  = 3 * C_WORD_W;

    // The impulse is always scaled by a Q16 step.
    localparam int C_IMP_SHIFT = 16;
    localparam int C_DV_W      = 64 - C_IMP_SHIFT;

    // Restitution factor e is Q16 and below 2^17. On a contact the magnitude
    // of d.u stays below 3*2^32, so 34 bits carry it.
    localparam int C_E_W    = 17;
    localparam int C_BMAG_W = 34;
    localparam int C_NUM_W  = C_E_W + C_BMAG_W;

    // Opcodes of the input word.
    localparam logic [C_OP_W-1:0] OP_WR_POS = 3'd0;
    localparam logic [C_OP_W-1:0] OP_WR_VEL = 3'd1;
    localparam logic [C_OP_W-1:0] OP_WR_IMG = 3'd2;
    localparam logic [C_OP_W-1:0] OP_RUN    = 3'd3;
    localparam logic [C_OP_W-1:0] OP_RD_VEL = 3'd4;

    // Kinds of the output word.
    localparam logic KIND_VEL  = 1'b0;
    localparam logic KIND_DONE = 1'b1;

    // Configuration register indexes.
    localparam logic [1:0] CFG_MOBILE = 2'd0;
    localparam logic [1:0] CFG_TOTAL  = 2'd1;
    localparam logic [1:0] CFG_REST   = 2'd2;
    localparam logic [1:0] CFG_PLANAR = 2'd3;

    // Stage enables from the sequencer to the lanes.
    typedef struct packed {
        logic en_d;
        logic en_p;
        logic en_c;
        logic en_u;
        logic fixed;
    } t_lane_ctl;

    // Saturate a wide signed value to a signed 32-bit word.
    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        if (v > 64'sd2147483647) begin
            return 32'sh7fffffff;
        end else if (v < -64'sd2147483648) begin
            return 32'sh80000000;
        end else begin
            return v[31:0];
        end
    endfunction

endpackage

@@ rtl/particle_collision_velocity_update_unit.sv @@
// Channel   Dir  Payload (lowest bit first)                      Accepted when
// s_axis    in   tuser: opcode; tdata: item_index, comp_x/y/z     tvalid & tready
// m_axis    out  tuser: result_kind; tdata: result_index, vel_x/y/z  tvalid & tready
// cfg       in   i_cfg_index, i_cfg_data                          i_cfg_valid & o_cfg_ready
//
// Position, velocity and image writes are stored when the word is accepted; a velocity
// read passes through S_RDOUT before its output word is loaded. A run visits every
// (i, j, image) triple through S_RD, S_DIF, S_PROD and S_MERGE; a contact adds S_EBMUL,
// S_DIVS, S_DIVW (the bit-serial divider forms (1+e)/2*B/r), S_CMUL, S_UPD, S_WRI and,
// with a mobile partner, S_WRJ. Input is held off until the run has finished.
// Reset is synchronous; the stores are not cleared and hold what was written.
// A waiting output word holds all further s_axis input until it is taken.
module particle_collision_velocity_update_unit #(
    parameter int MAX_PARTICLES = pcvu_pkg::C_MAX_PARTICLES,
    parameter int MAX_IMAGES    = pcvu_pkg::C_MAX_IMAGES,
    parameter int FRAC_BITS     = pcvu_pkg::C_FRAC_BITS
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    input  logic [103:0]  s_axis_tdata,   // item_index, comp_x, comp_y, comp_z
    input  logic [2:0]    s_axis_tuser,   // opcode
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    output logic [103:0]  m_axis_tdata,   // result_index, vel_x, vel_y, vel_z
    output logic          m_axis_tuser,   // result_kind
    input  logic          i_cfg_valid,
    output logic          o_cfg_ready,
    input  logic [1:0]    i_cfg_index,
    input  logic [16:0]   i_cfg_data
);

    localparam int AW  = $clog2(MAX_PARTICLES);
    localparam int CW  = $clog2(MAX_PARTICLES + 1);
    localparam int KW  = $clog2(MAX_IMAGES);
    localparam int XW  = (AW > pcvu_pkg::C_IDX_W) ? AW : pcvu_pkg::C_IDX_W;
    localparam int PW  = 64 - FRAC_BITS;
    localparam int BW  = PW + 2;
    localparam int DW  = FRAC_BITS + 2;
    localparam int NW  = pcvu_pkg::C_NUM_W;
    localparam int RW  = pcvu_pkg::C_ROW_W;
    localparam int N3D = (pcvu_pkg::C_IMG_3D > MAX_IMAGES) ? MAX_IMAGES : pcvu_pkg::C_IMG_3D;
    localparam int N2D = (pcvu_pkg::C_IMG_2D > MAX_IMAGES) ? MAX_IMAGES : pcvu_pkg::C_IMG_2D;
    localparam logic signed [63:0] RLIM = 64'sd4 <<< FRAC_BITS;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_RDOUT = 4'd1;
    localparam logic [3:0] S_RD    = 4'd2;
    localparam logic [3:0] S_DIF   = 4'd3;
    localparam logic [3:0] S_PROD  = 4'd4;
    localparam logic [3:0] S_MERGE = 4'd5;
    localparam logic [3:0] S_EBMUL = 4'd6;
    localparam logic [3:0] S_DIVS  = 4'd7;
    localparam logic [3:0] S_DIVW  = 4'd8;
    localparam logic [3:0] S_CMUL  = 4'd9;
    localparam logic [3:0] S_UPD   = 4'd10;
    localparam logic [3:0] S_WRI   = 4'd11;
    localparam logic [3:0] S_WRJ   = 4'd12;
    localparam logic [3:0] S_FIN   = 4'd13;

    logic [3:0]    r_state, n_state;
    logic [AW-1:0] r_i, n_i, r_j, n_j;
    logic [KW-1:0] r_k, n_k;
    logic [8:0]    r_mobile, r_total;
    logic [16:0]   r_rest;
    logic          r_planar;

    logic          r_out_valid;
    logic          r_out_kind;
    logic [7:0]    r_out_idx;
    logic [RW-1:0] r_out_vel;
    logic [7:0]    r_rd_idx;
    logic          r_rd_oob;

    logic [RW-1:0] pos_mem [MAX_PARTICLES];
    logic [RW-1:0] vel_mem [MAX_PARTICLES];
    logic [RW-1:0] img_mem [MAX_IMAGES];
    logic [RW-1:0] r_pos_a, r_pos_b, r_vel_a, r_vel_b, r_img;

    logic                         r_fixed;
    logic [pcvu_pkg::C_BMAG_W-1:0] r_bmag;
    logic [DW-1:0]                r_den;
    logic [NW-1:0]                r_num;
    logic signed [31:0]           r_c;

    logic [2:0]    in_op;
    logic [7:0]    in_idx;
    logic [XW-1:0] in_idx_x;
    logic [AW-1:0] in_addr;
    logic          in_ok, img_ok, accept;
    logic [CW-1:0] nm, np, jend;
    logic          i_last, j_last, k_last, is_fixed, run_done;
    logic [KW-1:0] k_max;
    logic [16:0]   e_w;
    logic          vel_we;
    logic [AW-1:0] vel_wa, vel_ra;
    logic [RW-1:0] vel_wd, row_i, row_j;
    logic          vel_re;

    pcvu_pkg::t_lane_ctl lane_ctl;
    logic signed [PW-1:0] bu [3];
    logic signed [PW-1:0] rr [3];
    logic signed [31:0]   nvi [3];
    logic signed [31:0]   nvj [3];
    logic signed [BW-1:0] b_sum, r_sum, b_neg;
    logic                 collide;
    logic                 div_done;
    logic [NW-1:0]        div_q;
    logic signed [31:0]   c_w;

    // Input word decode.
    always_comb begin
        in_op    = s_axis_tuser;
        in_idx   = s_axis_tdata[7:0];
        in_idx_x = XW'(in_idx);
        in_addr  = in_idx_x[AW-1:0];
        in_ok    = (int'(in_idx) < MAX_PARTICLES);
        img_ok   = (int'(in_idx) < MAX_IMAGES);
        accept   = s_axis_tvalid && s_axis_tready;
    end

    assign s_axis_tready = (r_state == S_IDLE) && (!r_out_valid || m_axis_tready);
    assign o_cfg_ready   = 1'b1;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mobile <= '0;
            r_total  <= '0;
            r_rest   <= 17'h10000;
            r_planar <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                pcvu_pkg::CFG_MOBILE: r_mobile <= i_cfg_data[8:0];
                pcvu_pkg::CFG_TOTAL:  r_total  <= i_cfg_data[8:0];
                pcvu_pkg::CFG_REST:   r_rest   <= i_cfg_data;
                pcvu_pkg::CFG_PLANAR: r_planar <= i_cfg_data[0];
                default:              r_planar <= r_planar;
            endcase
        end
    end

    // Loop bounds of a run.
    always_comb begin
        nm       = (int'(r_mobile) > MAX_PARTICLES) ? CW'(MAX_PARTICLES) : CW'(r_mobile);
        np       = (int'(r_total) > MAX_PARTICLES) ? CW'(MAX_PARTICLES) : CW'(r_total);
        jend     = (np > nm) ? np : nm;
        k_max    = r_planar ? KW'(N2D - 1) : KW'(N3D - 1);
        i_last   = (CW'(r_i) + CW'(1) == nm);
        j_last   = (CW'(r_j) + CW'(1) == jend);
        k_last   = (r_k == k_max);
        is_fixed = (CW'(r_j) >= nm);
        e_w      = 17'((18'h10000 + 18'(r_rest)) >> 1);
    end

    // Next triple of the walk: image fastest, then partner, then particle.
    always_comb begin
        n_i      = r_i;
        n_j      = r_j;
        n_k      = r_k + KW'(1);
        run_done = 1'b0;
        if (k_last) begin
            n_k = '0;
            n_j = r_j + AW'(1);
            if (j_last) begin
                n_j = '0;
                n_i = r_i + AW'(1);
                run_done = i_last;
            end
        end
    end

    // Position and image stores.
    always_ff @(posedge i_clk) begin
        if (accept && in_op == pcvu_pkg::OP_WR_POS && in_ok) begin
            pos_mem[in_addr] <= s_axis_tdata[103:8];
        end
        if (r_state == S_RD) begin
            r_pos_a <= pos_mem[r_i];
            r_pos_b <= pos_mem[r_j];
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && in_op == pcvu_pkg::OP_WR_IMG && img_ok) begin
            img_mem[in_idx[KW-1:0]] <= s_axis_tdata[103:8];
        end
        if (r_state == S_RD) begin
            r_img <= img_mem[r_k];
        end
    end

    // Velocity store: one write port, two read ports.
    always_comb begin
        row_i  = {nvi[2], nvi[1], nvi[0]};
        row_j  = {nvj[2], nvj[1], nvj[0]};
        vel_we = (accept && in_op == pcvu_pkg::OP_WR_VEL && in_ok)
                 || (r_state == S_WRI) || (r_state == S_WRJ);
        vel_wa = (r_state == S_WRI) ? r_i : ((r_state == S_WRJ) ? r_j : in_addr);
        vel_wd = (r_state == S_WRI) ? row_i
                 : ((r_state == S_WRJ) ? row_j : s_axis_tdata[103:8]);
        vel_re = (accept && in_op == pcvu_pkg::OP_RD_VEL) || (r_state == S_RD);
        vel_ra = (r_state == S_RD) ? r_i : in_addr;
    end

    always_ff @(posedge i_clk) begin
        if (vel_we) begin
            vel_mem[vel_wa] <= vel_wd;
        end
        if (vel_re) begin
            r_vel_a <= vel_mem[vel_ra];
        end
        if (r_state == S_RD) begin
            r_vel_b <= vel_mem[r_j];
        end
    end

    // One lane for each axis.
    always_comb begin
        lane_ctl.en_d  = (r_state == S_DIF);
        lane_ctl.en_p  = (r_state == S_PROD);
        lane_ctl.en_c  = (r_state == S_CMUL);
        lane_ctl.en_u  = (r_state == S_UPD);
        lane_ctl.fixed = r_fixed;
    end

    for (genvar g = 0; g < 3; g++) begin : g_lane
        pcvu_lane #(.FRAC_BITS(FRAC_BITS)) u_lane (
            .i_clk   (i_clk),
            .i_ctl   (lane_ctl),
            .i_active((g != 2) || !r_planar),
            .i_pos_i (r_pos_a[32*g +: 32]),
            .i_pos_j (r_pos_b[32*g +: 32]),
            .i_img   (r_img[32*g +: 32]),
            .i_vel_i (r_vel_a[32*g +: 32]),
            .i_vel_j (r_vel_b[32*g +: 32]),
            .i_c     (r_c),
            .o_bu    (bu[g]),
            .o_rr    (rr[g]),
            .o_vel_i (nvi[g]),
            .o_vel_j (nvj[g])
        );
    end

    // Merge the lanes into d.u and d.d and test for contact.
    always_comb begin
        b_sum   = BW'(bu[0]) + BW'(bu[1]) + BW'(bu[2]);
        r_sum   = BW'(rr[0]) + BW'(rr[1]) + BW'(rr[2]);
        b_neg   = -b_sum;
        collide = (b_sum < 0) && (64'(r_sum) < RLIM);
        c_w     = (div_q >= NW'(64'h80000000)) ? 32'sh80000000 : -$signed(div_q[31:0]);
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_RD) begin
            r_fixed <= is_fixed;
        end
        if (r_state == S_MERGE) begin
            r_bmag <= b_neg[pcvu_pkg::C_BMAG_W-1:0];
            r_den  <= (r_sum == 0) ? DW'(1) : r_sum[DW-1:0];
        end
        if (r_state == S_EBMUL) begin
            r_num <= NW'(e_w) * NW'(r_bmag);
        end
        if (r_state == S_DIVW && div_done) begin
            r_c <= c_w;
        end
    end

    pcvu_div #(.NW(NW), .DW(DW)) u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(r_state == S_DIVS),
        .i_num  (r_num),
        .i_den  (r_den),
        .o_done (div_done),
        .o_quot (div_q)
    );

    // Sequencer.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept && in_op == pcvu_pkg::OP_RD_VEL) begin
                    n_state = S_RDOUT;
                end else if (accept && in_op == pcvu_pkg::OP_RUN) begin
                    n_state = (nm == '0) ? S_FIN : S_RD;
                end
            end
            S_RDOUT: n_state = S_IDLE;
            S_RD:    n_state = S_DIF;
            S_DIF:   n_state = S_PROD;
            S_PROD:  n_state = S_MERGE;
            S_MERGE: begin
                if (collide) begin
                    n_state = S_EBMUL;
                end else begin
                    n_state = run_done ? S_FIN : S_RD;
                end
            end
            S_EBMUL: n_state = S_DIVS;
            S_DIVS:  n_state = S_DIVW;
            S_DIVW:  n_state = div_done ? S_CMUL : S_DIVW;
            S_CMUL:  n_state = S_UPD;
            S_UPD:   n_state = S_WRI;
            S_WRI: begin
                if (!r_fixed) begin
                    n_state = S_WRJ;
                end else begin
                    n_state = run_done ? S_FIN : S_RD;
                end
            end
            S_WRJ:   n_state = run_done ? S_FIN : S_RD;
            S_FIN:   n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_i     <= '0;
            r_j     <= '0;
            r_k     <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_IDLE) begin
                r_i <= '0;
                r_j <= '0;
                r_k <= '0;
            end else if ((r_state == S_MERGE && !collide) || (r_state == S_WRI && r_fixed)
                         || r_state == S_WRJ) begin
                r_i <= n_i;
                r_j <= n_j;
                r_k <= n_k;
            end
        end
    end

    // Output word register.
    always_ff @(posedge i_clk) begin
        if (accept && in_op == pcvu_pkg::OP_RD_VEL) begin
            r_rd_idx <= in_idx;
            r_rd_oob <= !in_ok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_RDOUT || r_state == S_FIN) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_RDOUT) begin
            r_out_kind <= pcvu_pkg::KIND_VEL;
            r_out_idx  <= r_rd_idx;
            r_out_vel  <= r_rd_oob ? '0 : r_vel_a;
        end else if (r_state == S_FIN) begin
            r_out_kind <= pcvu_pkg::KIND_DONE;
            r_out_idx  <= '0;
            r_out_vel  <= '0;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_kind;
    assign m_axis_tdata  = {r_out_vel, r_out_idx};

    // An output word is only loaded into an empty register.
    a_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RDOUT || r_state == S_FIN) |-> !r_out_valid)
        else $error("output word loaded over a pending word");

    // Input is taken only while the sequencer is idle.
    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> (r_state == S_IDLE))
        else $error("input ready outside idle");

    // The divider finishes only while the sequencer waits on it.
    a_div_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == S_DIVW))
        else $error("divider result with no waiting contact");

    // A contact always leads to a write of particle i.
    a_upd_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_UPD) |=> (r_state == S_WRI))
        else $error("velocity update not written back");

endmodule

@@ rtl/pcvu_lane.sv @@
module pcvu_lane #(
    parameter int FRAC_BITS = pcvu_pkg::C_FRAC_BITS,
    localparam int PW = 64 - FRAC_BITS
) (
    input  logic                    i_clk,
    input  pcvu_pkg::t_lane_ctl     i_ctl,
    input  logic                    i_active,
    input  logic signed [31:0]      i_pos_i,
    input  logic signed [31:0]      i_pos_j,
    input  logic signed [31:0]      i_img,
    input  logic signed [31:0]      i_vel_i,
    input  logic signed [31:0]      i_vel_j,
    input  logic signed [31:0]      i_c,
    output logic signed [PW-1:0]    o_bu,
    output logic signed [PW-1:0]    o_rr,
    output logic signed [31:0]      o_vel_i,
    output logic signed [31:0]      o_vel_j
);

    localparam logic signed [63:0] FRAC_MASK = (64'sd1 <<< FRAC_BITS) - 64'sd1;
    localparam logic signed [63:0] IMP_MASK  = (64'sd1 <<< pcvu_pkg::C_IMP_SHIFT) - 64'sd1;

    logic signed [31:0] r_d, r_u;
    logic signed [33:0] d_w, u_w;
    logic signed [63:0] p_du, p_dd, p_dc, s_du, s_dd, s_dc;
    logic signed [pcvu_pkg::C_DV_W-1:0] r_dv;
    logic signed [50:0] vi_w, vj_w, dv_w;

    // Relative position and velocity, saturated to one word.
    always_comb begin
        d_w = 34'(i_pos_i) - 34'(i_pos_j) - 34'(i_img);
        u_w = 34'(i_vel_i) - 34'(i_vel_j);
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en_d) begin
            r_d <= i_active ? pcvu_pkg::sat32(64'(d_w)) : 32'sd0;
            r_u <= i_ctl.fixed ? i_vel_i : pcvu_pkg::sat32(64'(u_w));
        end
    end

    // Products scaled back to the fixed-point format, truncated toward zero.
    always_comb begin
        p_du = 64'(r_d) * 64'(r_u);
        p_dd = 64'(r_d) * 64'(r_d);
        p_dc = 64'(r_d) * 64'(i_c);
        s_du = (p_du < 0) ? ((p_du + FRAC_MASK) >>> FRAC_BITS) : (p_du >>> FRAC_BITS);
        s_dd = p_dd >>> FRAC_BITS;
        s_dc = (p_dc < 0) ? ((p_dc + IMP_MASK) >>> pcvu_pkg::C_IMP_SHIFT)
                          : (p_dc >>> pcvu_pkg::C_IMP_SHIFT);
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en_p) begin
            o_bu <= s_du[PW-1:0];
            o_rr <= s_dd[PW-1:0];
        end
        if (i_ctl.en_c) begin
            r_dv <= s_dc[pcvu_pkg::C_DV_W-1:0];
        end
    end

    // Velocity updates; a fixed partner takes the doubled impulse on i only.
    always_comb begin
        dv_w = 51'(r_dv);
        vi_w = i_ctl.fixed ? (51'(i_vel_i) - (dv_w <<< 1)) : (51'(i_vel_i) - dv_w);
        vj_w = 51'(i_vel_j) + dv_w;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en_u) begin
            o_vel_i <= i_active ? pcvu_pkg::sat32(64'(vi_w)) : i_vel_i;
            o_vel_j <= i_active ? pcvu_pkg::sat32(64'(vj_w)) : i_vel_j;
        end
    end

endmodule

@@ rtl/pcvu_div.sv @@
module pcvu_div #(
    parameter int NW = pcvu_pkg::C_NUM_W,
    parameter int DW = pcvu_pkg::C_FRAC_BITS + 2
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    output logic          o_done,
    output logic [NW-1:0] o_quot
);

    localparam int CNT_W = $clog2(NW + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DW-1:0]    r_rem;
    logic [DW-1:0]    r_den;
    logic [NW-1:0]    r_num;
    logic [NW-1:0]    r_quot;
    logic [DW:0]      trial;
    logic             take;

    // One restoring step: bring down the next numerator bit and subtract.
    always_comb begin
        trial = {r_rem, r_num[NW-1]};
        take  = (trial >= {1'b0, r_den});
    end

    // Control: busy for NW steps after a start, then a done pulse.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(NW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_den <= i_den;
            r_num <= i_num;
        end else if (r_busy) begin
            r_rem  <= take ? DW'(trial - {1'b0, r_den}) : trial[DW-1:0];
            r_num  <= {r_num[NW-2:0], 1'b0};
            r_quot <= {r_quot[NW-2:0], take};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

@@ tb/testbench.sv @@
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NPART = pcvu_pkg::C_MAX_PARTICLES;
    localparam int NIMG = pcvu_pkg::C_MAX_IMAGES;
    localparam int RANDOM_WORDS = 1440;
    localparam int PHASES = 8;
    localparam longint CYCLE_LIMIT = 10_000_000;
    localparam longint ONE_Q = 64'sd65536;

    // One expected output word.
    typedef struct {
        logic kind;
        logic [7:0] idx;
        logic [31:0] vx;
        logic [31:0] vy;
        logic [31:0] vz;
    } t_vel_word;

    // One row of the directed table: either a register write or an input word.
    typedef struct {
        bit is_cfg;
        logic [1:0] reg_idx;
        logic [16:0] reg_val;
        logic [2:0] op;
        logic [7:0] idx;
        logic [31:0] cx;
        logic [31:0] cy;
        logic [31:0] cz;
        bit typed;
        t_vel_word want;
    } t_dir_row;

    logic i_clk;
    logic i_rst_n;
    logic s_axis_tvalid;
    logic s_axis_tready;
    logic [103:0] s_axis_tdata;   // item_index, comp_x, comp_y, comp_z
    logic [2:0] s_axis_tuser;     // opcode
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [103:0] m_axis_tdata;   // result_index, vel_x, vel_y, vel_z
    logic m_axis_tuser;           // result_kind
    logic i_cfg_valid;
    logic o_cfg_ready;
    logic [1:0] i_cfg_index;
    logic [16:0] i_cfg_data;

    // Shadow copy of the block state.
    int pos_mem [NPART][3];
    int vel_mem [NPART][3];
    int img_mem [NIMG][3];
    int unsigned n_mobile;
    int unsigned n_total;
    int unsigned rest_q;
    bit planar;

    t_vel_word vel_words_due [$];
    int errors = 0;
    longint cycles = 0;
    int stall_mode = 0;

    particle_collision_velocity_update_unit u_top (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tuser(m_axis_tuser),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic longint clamp_word(longint v);
        if (v > 64'sd2147483647) begin
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648) begin
            return -64'sd2147483648;
        end
        return v;
    endfunction

    // Contact test and impulse exchange for particle i against partner j seen
    // through image k.
    function automatic void contact_step(int i, int j, int k, int dims, bit fixed_j,
                                         longint e_q);
        longint d [3];
        longint u [3];
        longint b;
        longint r;
        longint c;
        longint dv;
        b = 0;
        r = 0;
        for (int m = 0; m < dims; m++) begin
            d[m] = clamp_word(longint'(pos_mem[i][m]) - longint'(pos_mem[j][m])
                              - longint'(img_mem[k][m]));
            if (fixed_j) begin
                u[m] = vel_mem[i][m];
            end else begin
                u[m] = clamp_word(longint'(vel_mem[i][m]) - longint'(vel_mem[j][m]));
            end
            b += (d[m] * u[m]) / ONE_Q;
            r += (d[m] * d[m]) / ONE_Q;
        end
        if (!(b < 0 && r < 4 * ONE_Q)) begin
            return;
        end
        if (r == 0) begin
            r = 1;
        end
        c = clamp_word((e_q * b) / r);
        for (int m = 0; m < dims; m++) begin
            dv = (d[m] * c) / 65536;
            if (fixed_j) begin
                vel_mem[i][m] = int'(clamp_word(longint'(vel_mem[i][m]) - 2 * dv));
            end else begin
                vel_mem[i][m] = int'(clamp_word(longint'(vel_mem[i][m]) - dv));
                vel_mem[j][m] = int'(clamp_word(longint'(vel_mem[j][m]) + dv));
            end
        end
    endfunction

    // Applies one accepted input word to the shadow state and returns whether
    // it produces an output word.
    function automatic bit predict_velocity(logic [2:0] op, logic [7:0] idx,
                                            logic [31:0] cx, logic [31:0] cy,
                                            logic [31:0] cz, output t_vel_word w);
        int nm;
        int np;
        int dims;
        int nimg;
        longint e_q;
        w = '{kind: pcvu_pkg::KIND_VEL, idx: idx, vx: '0, vy: '0, vz: '0};
        case (op)
            pcvu_pkg::OP_WR_POS: begin
                pos_mem[idx] = '{cx, cy, cz};
                return 1'b0;
            end
            pcvu_pkg::OP_WR_VEL: begin
                vel_mem[idx] = '{cx, cy, cz};
                return 1'b0;
            end
            pcvu_pkg::OP_WR_IMG: begin
                if (idx < NIMG) begin
                    img_mem[idx] = '{cx, cy, cz};
                end
                return 1'b0;
            end
            pcvu_pkg::OP_RUN: begin
                nm = (n_mobile > NPART) ? NPART : n_mobile;
                np = (n_total > NPART) ? NPART : n_total;
                dims = planar ? 2 : 3;
                nimg = planar ? pcvu_pkg::C_IMG_2D : pcvu_pkg::C_IMG_3D;
                if (nimg > NIMG) begin
                    nimg = NIMG;
                end
                e_q = (65536 + longint'(rest_q)) / 2;
                for (int i = 0; i < nm; i++) begin
                    for (int j = 0; j < nm; j++) begin
                        for (int k = 0; k < nimg; k++) begin
                            contact_step(i, j, k, dims, 1'b0, e_q);
                        end
                    end
                    for (int j = nm; j < np; j++) begin
                        for (int k = 0; k < nimg; k++) begin
                            contact_step(i, j, k, dims, 1'b1, e_q);
                        end
                    end
                end
                w = '{kind: pcvu_pkg::KIND_DONE, idx: '0, vx: '0, vy: '0, vz: '0};
                return 1'b1;
            end
            pcvu_pkg::OP_RD_VEL: begin
                w.vx = vel_mem[idx][0];
                w.vy = vel_mem[idx][1];
                w.vz = vel_mem[idx][2];
                return 1'b1;
            end
            default: return 1'b0;
        endcase
    endfunction

    // Sends one word after a random gap, keeping valid high inside a burst.
    task automatic send_word(logic [2:0] op, logic [7:0] idx, logic [31:0] cx,
                             logic [31:0] cy, logic [31:0] cz);
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= op;
        s_axis_tdata <= {cz, cy, cx, idx};
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // Word accepted: record what it should produce.
    task automatic send_checked(logic [2:0] op, logic [7:0] idx, logic [31:0] cx,
                                logic [31:0] cy, logic [31:0] cz);
        t_vel_word w;
        send_word(op, idx, cx, cy, cz);
        if (predict_velocity(op, idx, cx, cy, cz, w)) begin
            vel_words_due.push_back(w);
        end
    endtask

    // Register write once the block has drained.
    task automatic write_reg(logic [1:0] ridx, logic [16:0] val);
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (vel_words_due.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= ridx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (ridx)
            pcvu_pkg::CFG_MOBILE: n_mobile = val[8:0];
            pcvu_pkg::CFG_TOTAL: n_total = val[8:0];
            pcvu_pkg::CFG_REST: rest_q = val;
            default: planar = val[0];
        endcase
    endtask

    function automatic logic [31:0] rand_coord();
        int pick;
        pick = $urandom_range(0, 19);
        if (pick < 14) begin
            return $urandom_range(0, 393216) - 196608;
        end else if (pick < 16) begin
            return pick[0] ? 32'h7fffffff : 32'h80000000;
        end
        return $urandom;
    endfunction

    function automatic logic [31:0] rand_offset();
        int pick;
        pick = $urandom_range(0, 3);
        if (pick == 0) begin
            return '0;
        end else if (pick == 1) begin
            return ($urandom_range(0, 1) ? 1 : -1) * 262144 * $urandom_range(1, 3);
        end else if (pick == 2) begin
            return $urandom_range(0, 131072) - 65536;
        end
        return $urandom;
    endfunction

    // Sampling of results at the clock edge.
    always @(posedge i_clk) begin
        t_vel_word w;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (vel_words_due.size() == 0) begin
                $error("unexpected output word kind=%0d data=%h", m_axis_tuser,
                       m_axis_tdata);
                errors++;
            end else begin
                w = vel_words_due.pop_front();
                if (m_axis_tuser !== w.kind) begin
                    $error("result_kind expected %0d actual %0d", w.kind, m_axis_tuser);
                    errors++;
                end
                if (m_axis_tdata[7:0] !== w.idx) begin
                    $error("result_index expected %0d actual %0d", w.idx,
                           m_axis_tdata[7:0]);
                    errors++;
                end
                if (m_axis_tdata[39:8] !== w.vx) begin
                    $error("vel_x expected %h actual %h", w.vx, m_axis_tdata[39:8]);
                    errors++;
                end
                if (m_axis_tdata[71:40] !== w.vy) begin
                    $error("vel_y expected %h actual %h", w.vy, m_axis_tdata[71:40]);
                    errors++;
                end
                if (m_axis_tdata[103:72] !== w.vz) begin
                    $error("vel_z expected %h actual %h", w.vz, m_axis_tdata[103:72]);
                    errors++;
                end
            end
        end
    end

    // Receiver stalls: the pattern is chosen at random from four.
    always @(posedge i_clk) begin
        if (cycles % 64 == 0) begin
            stall_mode <= $urandom_range(0, 3);
        end
        case (stall_mode)
            0: m_axis_tready <= 1'b1;
            1: m_axis_tready <= ($urandom_range(0, 3) != 0);
            2: m_axis_tready <= ($urandom_range(0, 3) == 0);
            default: m_axis_tready <= cycles[2];
        endcase
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        t_dir_row rows [$];
        t_vel_word w;
        int pick;
        logic [2:0] op;
        logic [7:0] idx;
        bit runs_allowed;

        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        n_mobile = 0;
        n_total = 0;
        rest_q = 65536;
        planar = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Fill every store entry so that no run or read touches an unwritten one.
        for (int p = 0; p < NPART; p++) begin
            send_checked(pcvu_pkg::OP_WR_POS, p[7:0], rand_coord(), rand_coord(),
                         rand_coord());
            send_checked(pcvu_pkg::OP_WR_VEL, p[7:0], rand_coord(), rand_coord(),
                         rand_coord());
        end
        for (int k = 0; k < NIMG; k++) begin
            send_checked(pcvu_pkg::OP_WR_IMG, k[7:0], (k == 0) ? '0 : rand_offset(),
                         rand_offset(), rand_offset());
        end

        // Directed table: extremes, every opcode, ignored words and the
        // truncated-distance contact.
        rows = '{
            '{0, pcvu_pkg::CFG_MOBILE, 0, pcvu_pkg::OP_RUN, 8'd0, 0, 0, 0, 1,
              '{pcvu_pkg::KIND_DONE, 8'd0, 32'd0, 32'd0, 32'd0}},
            '{0, pcvu_pkg::CFG_MOBILE, 0, pcvu_pkg::OP_WR_VEL, 8'd255, 32'h7fffffff,
              32'h80000000, 32'hffffffff, 0, '{pcvu_pkg::KIND_VEL, 0, 0, 0, 0}},
            '{0, pcvu_pkg::CFG_MOBILE, 0, pcvu_pkg::OP_RD_VEL, 8'd255, 32'h12345678, 0, 0, 1,
              '{pcvu_pkg::KIND_VEL, 8'd255, 32'h7fffffff, 32'h80000000, 32'hffffffff}},
            '{0, pcvu_pkg::CFG_MOBILE, 0, pcvu_pkg::OP_WR_POS, 8'd254, 32'h80000000,
              32'h7fffffff, 0, 0, '{pcvu_pkg::KIND_VEL, 0, 0, 0, 0}},
            '{0, pcvu_pkg::CFG_MOBILE, 0, pcvu_pkg::OP_WR_IMG, 8'd200, 32'h7fffffff, 0, 0, 0,
              '{pcvu_pkg::KIND_VEL, 0, 0, 0, 0}},
            '{0, pcvu_pkg::CFG_MOBILE, 0, 3'd5, 8'd1, 0, 0, 0, 0,
              '{pcvu_pkg::KIND_VEL, 0, 0, 0, 0}},
            '{0, pcvu_pkg::CFG_MOBILE, 0, 3'd6, 8'd2, 0, 0, 0, 0,
              '{pcvu_pkg::KIND_VEL, 0, 0, 0, 0}},
            '{0, pcvu_pkg::CFG_MOBILE, 0, 3'd7, 8'd3, 0, 0, 0, 0,
              '{pcvu_pkg::KIND_VEL, 0, 0, 0, 0}},
            '{0, pcvu_pkg::CFG_MOBILE, 0, pcvu_pkg::OP_RD_VEL, 8'd0, 0, 0, 0, 0,
              '{pcvu_pkg::KIND_VEL, 0, 0, 0, 0}},
            // Particles one unit of the last place apart, closing in: r truncates to zero.
            '{0, pcvu_pkg::CFG_MOBILE, 0, pcvu_pkg::OP_WR_POS, 8'd0, 0, 0, 0, 0,
              '{pcvu_pkg::KIND_VEL, 0, 0, 0, 0}},
            '{0, pcvu_pkg::CFG_MOBILE, 0, pcvu_pkg::OP_WR_POS, 8'd1, 1, 0, 0, 0,
              '{pcvu_pkg::KIND_VEL, 0, 0, 0, 0}},
            '{0, pcvu_pkg::CFG_MOBILE, 0, pcvu_pkg::OP_WR_VEL, 8'd0, 131072, 0, 0, 0,
              '{pcvu_pkg::KIND_VEL, 0, 0, 0, 0}},
            '{0, pcvu_pkg::CFG_MOBILE, 0, pcvu_pkg::OP_WR_VEL, 8'd1, 0, 0, 0, 0,
              '{pcvu_pkg::KIND_VEL, 0, 0, 0, 0}},
            // A fixed particle just touching particle 0.
            '{0, pcvu_pkg::CFG_MOBILE, 0, pcvu_pkg::OP_WR_POS, 8'd2, 32'hfffe8000, 0, 0, 0,
              '{pcvu_pkg::KIND_VEL, 0, 0, 0, 0}},
            '{0, pcvu_pkg::CFG_MOBILE, 0, pcvu_pkg::OP_WR_IMG, 8'd0, 0, 0, 0, 0,
              '{pcvu_pkg::KIND_VEL, 0, 0, 0, 0}},
            '{1, pcvu_pkg::CFG_MOBILE, 17'd2, 0, 0, 0, 0, 0, 0,
              '{pcvu_pkg::KIND_VEL, 0, 0, 0, 0}},
            '{1, pcvu_pkg::CFG_TOTAL, 17'd3, 0, 0, 0, 0, 0, 0,
              '{pcvu_pkg::KIND_VEL, 0, 0, 0, 0}},
            '{0, pcvu_pkg::CFG_MOBILE, 0, pcvu_pkg::OP_RUN, 8'd9, 32'hffffffff, 1, 1, 0,
              '{pcvu_pkg::KIND_VEL, 0, 0, 0, 0}},
            '{0, pcvu_pkg::CFG_MOBILE, 0, pcvu_pkg::OP_RD_VEL, 8'd0, 0, 0, 0, 0,
              '{pcvu_pkg::KIND_VEL, 0, 0, 0, 0}},
            '{0, pcvu_pkg::CFG_MOBILE, 0, pcvu_pkg::OP_RD_VEL, 8'd1, 0, 0, 0, 0,
              '{pcvu_pkg::KIND_VEL, 0, 0, 0, 0}},
            '{1, pcvu_pkg::CFG_PLANAR, 17'd1, 0, 0, 0, 0, 0, 0,
              '{pcvu_pkg::KIND_VEL, 0, 0, 0, 0}},
            '{1, pcvu_pkg::CFG_REST, 17'h1ffff, 0, 0, 0, 0, 0, 0,
              '{pcvu_pkg::KIND_VEL, 0, 0, 0, 0}},
            '{0, pcvu_pkg::CFG_MOBILE, 0, pcvu_pkg::OP_RUN, 8'd0, 0, 0, 0, 0,
              '{pcvu_pkg::KIND_VEL, 0, 0, 0, 0}},
            '{0, pcvu_pkg::CFG_MOBILE, 0, pcvu_pkg::OP_RD_VEL, 8'd0, 0, 0, 0, 0,
              '{pcvu_pkg::KIND_VEL, 0, 0, 0, 0}}
        };
        foreach (rows[n]) begin
            if (rows[n].is_cfg) begin
                write_reg(rows[n].reg_idx, rows[n].reg_val);
            end else if (rows[n].typed) begin
                send_word(rows[n].op, rows[n].idx, rows[n].cx, rows[n].cy, rows[n].cz);
                void'(predict_velocity(rows[n].op, rows[n].idx, rows[n].cx, rows[n].cy,
                                       rows[n].cz, w));
                vel_words_due.push_back(rows[n].want);
            end else begin
                send_checked(rows[n].op, rows[n].idx, rows[n].cx, rows[n].cy, rows[n].cz);
            end
        end

        // Random phases, each with its own setting of the registers.
        for (int ph = 0; ph < PHASES; ph++) begin
            runs_allowed = 1'b1;
            case (ph)
                0: begin
                    write_reg(pcvu_pkg::CFG_MOBILE, 17'd0);
                    write_reg(pcvu_pkg::CFG_TOTAL, 17'h1ff);
                end
                1: begin
                    // Clamped count: runs would take far too long here.
                    write_reg(pcvu_pkg::CFG_MOBILE, 17'h1ff);
                    write_reg(pcvu_pkg::CFG_TOTAL, 17'd256);
                    runs_allowed = 1'b0;
                end
                2: begin
                    write_reg(pcvu_pkg::CFG_MOBILE, 17'd3);
                    write_reg(pcvu_pkg::CFG_TOTAL, 17'd1);
                end
                default: begin
                    write_reg(pcvu_pkg::CFG_MOBILE, 17'($urandom_range(1, 3)));
                    write_reg(pcvu_pkg::CFG_TOTAL, 17'($urandom_range(0, 5)));
                end
            endcase
            case (ph % 4)
                0: write_reg(pcvu_pkg::CFG_REST, 17'd0);
                1: write_reg(pcvu_pkg::CFG_REST, 17'd65536);
                2: write_reg(pcvu_pkg::CFG_REST, 17'h1ffff);
                default: write_reg(pcvu_pkg::CFG_REST, 17'($urandom_range(0, 131071)));
            endcase
            write_reg(pcvu_pkg::CFG_PLANAR, 17'(ph[0]));
            for (int n = 0; n < RANDOM_WORDS / PHASES; n++) begin
                pick = $urandom_range(0, 99);
                idx = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 6));
                if (pick < 30) begin
                    op = pcvu_pkg::OP_WR_POS;
                end else if (pick < 55) begin
                    op = pcvu_pkg::OP_WR_VEL;
                end else if (pick < 67) begin
                    op = pcvu_pkg::OP_WR_IMG;
                    idx = 8'($urandom_range(0, 31));
                end else if (pick < 70) begin
                    op = runs_allowed ? pcvu_pkg::OP_RUN : pcvu_pkg::OP_RD_VEL;
                end else if (pick < 94) begin
                    op = pcvu_pkg::OP_RD_VEL;
                end else begin
                    op = 3'($urandom_range(5, 7));
                end
                if (op == pcvu_pkg::OP_WR_IMG) begin
                    send_checked(op, idx, rand_offset(), rand_offset(), rand_offset());
                end else begin
                    send_checked(op, idx, rand_coord(), rand_coord(), rand_coord());
                end
            end
        end

        // Drain and allow the output path to settle.
        s_axis_tvalid <= 1'b0;
        while (vel_words_due.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
